@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the port-level checker of the leaderboard block.
// Depends on nothing; take it in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define TKLB_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define TKLB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/tklb_pkg.sv @@
// Package of the top-k leaderboard block: field widths, slot layout and
// the classifier result type. Depends on nothing.
`default_nettype none

package tklb_pkg;

  localparam int unsigned BOARD_W = 2;
  localparam int unsigned ID_W    = 32;
  localparam int unsigned TAG_W   = 64;
  localparam int unsigned SCORE_W = 32;
  localparam int unsigned RANK_W  = 4;

  // One stored slot of a board.
  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [TAG_W-1:0]          tag;
    logic [ID_W-1:0]           id;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

  // Where a slot lands relative to the new score.
  typedef enum logic [1:0] {
    CAT_HI  = 2'd0,  // untouched, score above the new score
    CAT_MID = 2'd1,  // rewritten, or untouched with an equal score
    CAT_LO  = 2'd2   // untouched, score below the new score
  } cat_e;

  typedef struct packed {
    logic changed;
    cat_e cat;
  } cls_t;

endpackage

`default_nettype wire

@@ rtl/core/tklb_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. Depends on nothing.
`default_nettype none

module tklb_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 88
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/tklb_cls.sv @@
// Shared slot classifier: id match and signed score compare of one slot
// against the pending update. Depends on tklb_pkg.
`default_nettype none

module tklb_cls (
  input  wire tklb_pkg::slot_t slot_i,
  input  wire tklb_pkg::slot_t upd_i,
  input  wire logic            spare_i,
  input  wire logic            found_i,
  output tklb_pkg::cls_t       cls_o
);

  import tklb_pkg::*;

  logic changed;
  logic gt;
  logic eq;

  // The spare slot takes the update only when no ranked slot matched.
  assign changed = spare_i ? !found_i : (slot_i.id == upd_i.id);
  assign gt      = $signed(slot_i.score) > $signed(upd_i.score);
  assign eq      = slot_i.score == upd_i.score;

  always_comb begin
    cls_o.changed = changed;
    if (changed || eq) begin
      cls_o.cat = CAT_MID;
    end else if (gt) begin
      cls_o.cat = CAT_HI;
    end else begin
      cls_o.cat = CAT_LO;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/top_k_leaderboard_update_top.sv @@
// Top level of the top-k leaderboard update block: sequencer, slot RAM
// and output register. Depends on tklb_pkg, tklb_ram and tklb_cls.
`default_nettype none

// Channel  Dir  tdata (low bit up)                          tuser   tlast
// s_axis   in   entry_id[31:0] name_tag[95:32] score[127:96] board   -
// m_axis   out  rank[3:0] ranked_id[35:4] ranked_name_tag    out_board last
//               [99:36] ranked_score[131:100], zero pad
//
// Passes: one update runs a scan pass and a reorder pass over all
// RANK_DEPTH+1 slots, then an emit pass over the RANK_DEPTH ranks. The single
// read port of the slot RAM and the one shared classifier shape this: in the
// scan and reorder passes every slot is read and classified once.
// Reset: all boards read as zero until their first update; no clearing pass.
// Stalls: a stalled result holds the emit sequencer; the input stays not
// ready from acceptance until the last result is taken. An update for an
// unknown board is taken and dropped at once.

module top_k_leaderboard_update_top #(
  parameter int unsigned RANK_DEPTH  = 10,
  parameter int unsigned BOARD_COUNT = 4
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // entry_id[31:0], name_tag[95:32], score[127:96]
  input  wire logic [127:0] s_axis_tdata,
  // board[1:0]
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // rank[3:0], ranked_id[35:4], ranked_name_tag[99:36],
  // ranked_score[131:100], zero[135:132]
  output logic [135:0]      m_axis_tdata,
  // out_board[1:0]
  output logic [1:0]        m_axis_tuser,
  output logic              m_axis_tlast
);

  import tklb_pkg::*;

  localparam int unsigned SLOTS  = RANK_DEPTH + 1;
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
  localparam int unsigned DEPTH  = 2 * BOARD_COUNT * SLOTS;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned BIDX_W = (BOARD_COUNT > 1) ? $clog2(BOARD_COUNT) : 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_MOVE = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Update payload and where its board lives.
  slot_t             upd_q, upd_d;
  logic [1:0]        board_q, board_d;
  logic [BIDX_W-1:0] brd_q, brd_d;
  logic [AW-1:0]     base_old_q, base_old_d;
  logic [AW-1:0]     base_new_q, base_new_d;

  // Per board: ever written, and which bank holds the live ranking.
  logic [BOARD_COUNT-1:0] init_q, init_d;
  logic [BOARD_COUNT-1:0] sel_q, sel_d;

  // Read pipeline of the scan and reorder passes.
  logic [CNT_W-1:0] rd_cnt_q, rd_cnt_d;
  logic             pv_q, pv_d;
  logic [CNT_W-1:0] pidx_q, pidx_d;

  // Pass counters.
  logic             found_q, found_d;
  logic [CNT_W-1:0] n_hi_q, n_hi_d;
  logic [CNT_W-1:0] n_mid_q, n_mid_d;
  logic [CNT_W-1:0] run_hi_q, run_hi_d;
  logic [CNT_W-1:0] run_mid_q, run_mid_d;
  logic [CNT_W-1:0] run_lo_q, run_lo_d;

  // Emit side.
  logic             rd_have_q, rd_have_d;
  logic [CNT_W-1:0] em_cnt_q, em_cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             out_last_q, out_last_d;
  logic [1:0]       out_board_q, out_board_d;
  logic [RANK_W-1:0] out_rank_q, out_rank_d;
  slot_t            out_slot_q, out_slot_d;

  // RAM ports.
  logic              ram_rd_en;
  logic [AW-1:0]     ram_rd_addr;
  logic [SLOT_W-1:0] ram_rd_data;
  logic              ram_wr_en;
  logic [AW-1:0]     ram_wr_addr;
  slot_t             ram_wr_data;

  slot_t             slot_rd;
  cls_t              cls;
  logic              spare;
  logic              in_fire;
  logic              out_fire;
  logic              board_ok;
  logic [BIDX_W-1:0] brd_in;
  logic              load;
  logic              issue;
  logic              pass_end;
  logic [CNT_W-1:0]  dest;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign board_ok = 32'(s_axis_tuser) < BOARD_COUNT;
  assign brd_in   = BIDX_W'(s_axis_tuser);

  // A board never written reads as all zero.
  assign slot_rd  = init_q[brd_q] ? slot_t'(ram_rd_data) : '0;
  assign spare    = pidx_q == CNT_W'(SLOTS - 1);
  assign pass_end = pv_q && spare;

  tklb_cls u_cls (
    .slot_i  (slot_rd),
    .upd_i   (upd_q),
    .spare_i (spare),
    .found_i (found_q),
    .cls_o   (cls)
  );

  tklb_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  // Emit handshake: move fetched data into the output register when it
  // is free, and prefetch the next rank behind it.
  assign load  = (state_q == ST_EMIT) && rd_have_q && (!out_valid_q || m_axis_tready);
  always_comb begin
    issue = 1'b0;
    case (state_q)
      ST_SCAN, ST_MOVE: issue = rd_cnt_q < CNT_W'(SLOTS);
      ST_EMIT:          issue = (rd_cnt_q < CNT_W'(RANK_DEPTH)) && (!rd_have_q || load);
      default:          issue = 1'b0;
    endcase
  end

  assign ram_rd_en   = issue;
  assign ram_rd_addr = ((state_q == ST_EMIT) ? base_new_q : base_old_q) + AW'(rd_cnt_q);

  // Final place of a slot: higher scores first, then the equal group in
  // slot order, then the lower scores.
  always_comb begin
    case (cls.cat)
      CAT_HI:  dest = run_hi_q;
      CAT_MID: dest = CNT_W'(n_hi_q + run_mid_q);
      CAT_LO:  dest = CNT_W'(n_hi_q + n_mid_q + run_lo_q);
      default: dest = run_lo_q;
    endcase
  end

  assign ram_wr_en   = (state_q == ST_MOVE) && pv_q;
  assign ram_wr_addr = base_new_q + AW'(dest);
  assign ram_wr_data = cls.changed ? upd_q : slot_rd;

  always_comb begin
    state_d     = state_q;
    upd_d       = upd_q;
    board_d     = board_q;
    brd_d       = brd_q;
    base_old_d  = base_old_q;
    base_new_d  = base_new_q;
    init_d      = init_q;
    sel_d       = sel_q;
    rd_cnt_d    = rd_cnt_q;
    pv_d        = 1'b0;
    pidx_d      = pidx_q;
    found_d     = found_q;
    n_hi_d      = n_hi_q;
    n_mid_d     = n_mid_q;
    run_hi_d    = run_hi_q;
    run_mid_d   = run_mid_q;
    run_lo_d    = run_lo_q;
    rd_have_d   = rd_have_q;
    em_cnt_d    = em_cnt_q;
    out_valid_d = out_valid_q;
    out_last_d  = out_last_q;
    out_board_d = out_board_q;
    out_rank_d  = out_rank_q;
    out_slot_d  = out_slot_q;

    if (issue) begin
      rd_cnt_d = CNT_W'(rd_cnt_q + 1'b1);
    end

    case (state_q)
      ST_IDLE: begin
        // Drop updates for boards that do not exist.
        if (in_fire && board_ok) begin
          upd_d.id    = s_axis_tdata[31:0];
          upd_d.tag   = s_axis_tdata[95:32];
          upd_d.score = s_axis_tdata[127:96];
          board_d     = s_axis_tuser;
          brd_d       = brd_in;
          base_old_d  = AW'((32'(brd_in) * 2 + 32'(sel_q[brd_in])) * SLOTS);
          base_new_d  = AW'((32'(brd_in) * 2 + 32'(!sel_q[brd_in])) * SLOTS);
          rd_cnt_d    = '0;
          found_d     = 1'b0;
          n_hi_d      = '0;
          n_mid_d     = '0;
          state_d     = ST_SCAN;
        end
      end

      ST_SCAN: begin
        pv_d   = issue;
        pidx_d = rd_cnt_q;
        if (pv_q) begin
          if (!spare && cls.changed) begin
            found_d = 1'b1;
          end
          if (cls.cat == CAT_HI) begin
            n_hi_d = CNT_W'(n_hi_q + 1'b1);
          end
          if (cls.cat == CAT_MID) begin
            n_mid_d = CNT_W'(n_mid_q + 1'b1);
          end
        end
        if (pass_end) begin
          rd_cnt_d  = '0;
          run_hi_d  = '0;
          run_mid_d = '0;
          run_lo_d  = '0;
          state_d   = ST_MOVE;
        end
      end

      ST_MOVE: begin
        pv_d   = issue;
        pidx_d = rd_cnt_q;
        if (pv_q) begin
          case (cls.cat)
            CAT_HI:  run_hi_d  = CNT_W'(run_hi_q + 1'b1);
            CAT_MID: run_mid_d = CNT_W'(run_mid_q + 1'b1);
            default: run_lo_d  = CNT_W'(run_lo_q + 1'b1);
          endcase
        end
        if (pass_end) begin
          // Swap banks: the freshly written one is now the live ranking.
          rd_cnt_d      = '0;
          sel_d[brd_q]  = !sel_q[brd_q];
          init_d[brd_q] = 1'b1;
          rd_have_d     = 1'b0;
          em_cnt_d      = '0;
          state_d       = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (issue) begin
          rd_have_d = 1'b1;
        end else if (load) begin
          rd_have_d = 1'b0;
        end
        if (load) begin
          out_valid_d = 1'b1;
          out_board_d = board_q;
          out_rank_d  = RANK_W'(em_cnt_q);
          out_slot_d  = slot_rd;
          out_last_d  = em_cnt_q == CNT_W'(RANK_DEPTH - 1);
          em_cnt_d    = CNT_W'(em_cnt_q + 1'b1);
        end else if (out_fire) begin
          out_valid_d = 1'b0;
        end
        if (out_fire && out_last_q) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      init_q      <= '0;
      sel_q       <= '0;
      rd_cnt_q    <= '0;
      pv_q        <= 1'b0;
      found_q     <= 1'b0;
      n_hi_q      <= '0;
      n_mid_q     <= '0;
      run_hi_q    <= '0;
      run_mid_q   <= '0;
      run_lo_q    <= '0;
      rd_have_q   <= 1'b0;
      em_cnt_q    <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      sel_q       <= sel_d;
      rd_cnt_q    <= rd_cnt_d;
      pv_q        <= pv_d;
      found_q     <= found_d;
      n_hi_q      <= n_hi_d;
      n_mid_q     <= n_mid_d;
      run_hi_q    <= run_hi_d;
      run_mid_q   <= run_mid_d;
      run_lo_q    <= run_lo_d;
      rd_have_q   <= rd_have_d;
      em_cnt_q    <= em_cnt_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
    end
  end

  // Payload registers hold without reset.
  always_ff @(posedge clk_i) begin
    upd_q       <= upd_d;
    board_q     <= board_d;
    brd_q       <= brd_d;
    base_old_q  <= base_old_d;
    base_new_q  <= base_new_d;
    pidx_q      <= pidx_d;
    out_board_q <= out_board_d;
    out_rank_q  <= out_rank_d;
    out_slot_q  <= out_slot_d;
  end

  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_board_q;
  assign m_axis_tdata  = {4'b0000, out_slot_q.score, out_slot_q.tag, out_slot_q.id,
                          out_rank_q};

endmodule

`default_nettype wire

@@ rtl/core/tklb_checker.sv @@
// Port-level checker of the top-k leaderboard block and its bind to the
// top level. Depends on assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module tklb_checker #(
  parameter int unsigned RANK_DEPTH  = 10,
  parameter int unsigned BOARD_COUNT = 4
) (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic [1:0]   s_axis_tuser,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [135:0] m_axis_tdata,
  input wire logic         m_axis_tlast
);

  logic upd_take;
  logic last_take;
  logic last_shown;
  logic last_rank_ok;

  assign upd_take     = s_axis_tvalid && s_axis_tready && (32'(s_axis_tuser) < BOARD_COUNT);
  assign last_take    = m_axis_tvalid && m_axis_tready && m_axis_tlast;
  assign last_shown   = m_axis_tvalid && m_axis_tlast;
  assign last_rank_ok = m_axis_tdata[3:0] == 4'(RANK_DEPTH - 1);

  // No new update may be taken while results are still on offer.
  `TKLB_ASSERT_NOW(a_no_overlap, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready, "ready while busy")

  // A known board blocks the input until its ranking is out.
  `TKLB_ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, upd_take, !s_axis_tready, "ready after update")

  // Delivering the final rank frees the input at once.
  `TKLB_ASSERT_NEXT(a_ready_after_last, clk_i, rst_ni, last_take, s_axis_tready, "not ready after last")

  // The marked item is always the bottom rank.
  `TKLB_ASSERT_NOW(a_last_rank, clk_i, rst_ni, last_shown, last_rank_ok, "last on wrong rank")

endmodule

bind top_k_leaderboard_update_top tklb_checker #(
  .RANK_DEPTH  (RANK_DEPTH),
  .BOARD_COUNT (BOARD_COUNT)
) u_tklb_checker (.*);

`default_nettype wire

@@ tb/sv/leaderboard_standings_checker.sv @@
// Checker for the top-k leaderboard block: keeps its own copy of the four boards,
// predicts the ten standings that every update emits and compares them in order.
// Depends on tklb_pkg for the field widths and the slot layout.
`timescale 1ns / 100ps

module leaderboard_standings_checker #(
  parameter int unsigned RANK_DEPTH  = 10,
  parameter int unsigned BOARD_COUNT = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  input  logic                        s_axis_tready,
  input  logic [127:0]                s_axis_tdata,
  input  logic [tklb_pkg::BOARD_W-1:0] s_axis_tuser,
  input  logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic [135:0]                m_axis_tdata,
  input  logic [tklb_pkg::BOARD_W-1:0] m_axis_tuser,
  input  logic                        m_axis_tlast,
  output int unsigned                 mismatch_count_o,
  output int unsigned                 standings_left_o
);

  import tklb_pkg::*;

  localparam int unsigned SLOTS_PER_BOARD = RANK_DEPTH + 1;
  localparam int unsigned SLOT_TOTAL      = BOARD_COUNT * SLOTS_PER_BOARD;

  typedef struct packed {
    logic [BOARD_W-1:0]        board;
    logic [RANK_W-1:0]         rank;
    logic [ID_W-1:0]           id;
    logic [TAG_W-1:0]          tag;
    logic signed [SCORE_W-1:0] score;
    logic                      last;
  } standing_t;

  slot_t       board_slots [SLOT_TOTAL];
  standing_t   standings_due [$];
  int unsigned mismatches;

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch: %s got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Rewrite matching ranked slots or fill the spare, then reorder by score
  // (stable, highest first) and queue the ten standings.
  task automatic apply_update(logic [BOARD_W-1:0] board, logic [ID_W-1:0] id,
                              logic [TAG_W-1:0] tag, logic signed [SCORE_W-1:0] score);
    int unsigned base;
    int          j;
    bit          hit;
    slot_t       moving;
    standing_t   st;
    if (board >= BOARD_COUNT) return;
    base = board * SLOTS_PER_BOARD;
    hit  = 1'b0;
    for (int i = 0; i < RANK_DEPTH; i++) begin
      if (board_slots[base+i].id == id) begin
        board_slots[base+i].tag   = tag;
        board_slots[base+i].score = score;
        hit = 1'b1;
      end
    end
    if (!hit) begin
      board_slots[base+RANK_DEPTH].id    = id;
      board_slots[base+RANK_DEPTH].tag   = tag;
      board_slots[base+RANK_DEPTH].score = score;
    end
    for (int i = 1; i < SLOTS_PER_BOARD; i++) begin
      moving = board_slots[base+i];
      j = i;
      while (j > 0 && $signed(board_slots[base+j-1].score) < $signed(moving.score)) begin
        board_slots[base+j] = board_slots[base+j-1];
        j--;
      end
      board_slots[base+j] = moving;
    end
    for (int i = 0; i < RANK_DEPTH; i++) begin
      st.board = board;
      st.rank  = RANK_W'(i);
      st.id    = board_slots[base+i].id;
      st.tag   = board_slots[base+i].tag;
      st.score = board_slots[base+i].score;
      st.last  = (i == RANK_DEPTH - 1);
      standings_due.push_back(st);
    end
  endtask

  task automatic check_standing();
    standing_t want;
    if (standings_due.size() == 0) begin
      flag_mismatch("result with none pending", m_axis_tdata[63:0], '0);
      return;
    end
    want = standings_due.pop_front();
    if (m_axis_tuser != want.board)
      flag_mismatch("out_board", 64'(m_axis_tuser), 64'(want.board));
    if (m_axis_tdata[3:0] != want.rank)
      flag_mismatch("rank", 64'(m_axis_tdata[3:0]), 64'(want.rank));
    if (m_axis_tdata[35:4] != want.id)
      flag_mismatch("ranked_id", 64'(m_axis_tdata[35:4]), 64'(want.id));
    if (m_axis_tdata[99:36] != want.tag)
      flag_mismatch("ranked_name_tag", m_axis_tdata[99:36], want.tag);
    if (m_axis_tdata[131:100] != want.score)
      flag_mismatch("ranked_score", 64'(m_axis_tdata[131:100]), 64'(unsigned'(want.score)));
    if (m_axis_tdata[135:132] != '0)
      flag_mismatch("pad bits", 64'(m_axis_tdata[135:132]), '0);
    if (m_axis_tlast != want.last)
      flag_mismatch("last", 64'(m_axis_tlast), 64'(want.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_TOTAL; i++) board_slots[i] = '0;
      standings_due.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      standings_left_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_standing();
      if (s_axis_tvalid && s_axis_tready)
        apply_update(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[95:32],
                     s_axis_tdata[127:96]);
      mismatch_count_o <= mismatches;
      standings_left_o <= standings_due.size();
    end
  end

endmodule

@@ tb/sv/top_k_leaderboard_update_top_tb.sv @@
// Testbench top for the top-k leaderboard block: clock, reset, update stimulus,
// sink backpressure and the verdict. Depends on tklb_pkg, the block and
// leaderboard_standings_checker.
`timescale 1ns / 100ps

module top_k_leaderboard_update_top_tb;

  localparam int unsigned RANK_DEPTH   = 10;
  localparam int unsigned BOARD_COUNT  = 4;
  localparam int unsigned RANDOM_ITEMS = 240;
  localparam int unsigned CALM_ITEMS   = 40;   // final stretch without idling
  localparam int unsigned HOLD_AT_ITEM = 60;   // where the sink starts its long hold
  localparam int unsigned SINK_HOLD    = 400;  // cycles of the long sink hold
  localparam int unsigned SETTLE       = 80;   // wait once no standings are left
  localparam int unsigned CYCLE_LIMIT  = 400000;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;   // entry_id[31:0], name_tag[95:32], score[127:96]
  logic [1:0]   s_axis_tuser;   // board[1:0]
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [135:0] m_axis_tdata;   // rank, ranked_id, ranked_name_tag, ranked_score, pad
  logic [1:0]   m_axis_tuser;   // out_board[1:0]
  logic         m_axis_tlast;

  logic         pressure_go;    // ask the sink for its long hold
  logic         quiet_phase;    // no idling on either side from here on
  int unsigned  mismatch_count;
  int unsigned  standings_left;
  int unsigned  cycle_count = 0;

  top_k_leaderboard_update_top #(
    .RANK_DEPTH (RANK_DEPTH),
    .BOARD_COUNT(BOARD_COUNT)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  leaderboard_standings_checker #(
    .RANK_DEPTH (RANK_DEPTH),
    .BOARD_COUNT(BOARD_COUNT)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .m_axis_tlast    (m_axis_tlast),
    .mismatch_count_o(mismatch_count),
    .standings_left_o(standings_left)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Guard against a hung block: end the run once the cycle budget is spent.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Mostly ids from a small pool so that updates hit ranked entries and push
  // others out; id zero matches every slot that was never written.
  function automatic logic [31:0] pick_id();
    case ($urandom_range(0, 9))
      0:       pick_id = 32'd0;
      1, 2:    pick_id = $urandom;
      default: pick_id = $urandom_range(1, 12);
    endcase
  endfunction

  // Many small scores for ties, some full range, some at the extremes.
  function automatic logic [31:0] pick_score();
    case ($urandom_range(0, 9))
      0:          pick_score = 32'h7FFF_FFFF;
      1:          pick_score = 32'h8000_0000;
      2, 3, 4:    pick_score = $urandom;
      default:    pick_score = $urandom_range(0, 8) - 32'd4;
    endcase
  endfunction

  // Offer one update and hold it until the block takes it. Now and then drop
  // valid for a random burst first, unless calm is set.
  task automatic offer_update(logic [1:0] board, logic [31:0] id, logic [63:0] tag,
                              logic [31:0] score, bit calm);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {score, tag, id};
    s_axis_tuser  <= board;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Sink: random ready and stall bursts, one long hold while the source keeps
  // offering, and steady ready in the calm stretch.
  initial begin
    bit hold_served;
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (pressure_go && !hold_served) begin
        hold_served = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (SINK_HOLD) @(posedge clk_i);
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat (quiet_phase ? 1 : $urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  initial begin
    bit calm;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    pressure_go   <= 1'b0;
    quiet_phase   <= 1'b0;
    rst_ni        <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Board 0: id zero rewrites every cleared slot; dropping them below zero
    // lets the zero held in the spare slot rise back to the top.
    offer_update(2'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'd5, 1'b0);
    offer_update(2'd0, 32'd0, 64'h0123_4567_89AB_CDEF, -32'sd7, 1'b0);
    offer_update(2'd0, 32'd9, 64'h0, 32'd0, 1'b0);
    // Board 1: extremes of id, tag and score; a new entry equal to the
    // cleared scores falls below them; a matched top entry drops to the floor.
    offer_update(2'd1, 32'hFFFF_FFFF, 64'h0, 32'h7FFF_FFFF, 1'b0);
    offer_update(2'd1, 32'hAAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA, 32'd0, 1'b0);
    offer_update(2'd1, 32'h5555_5555, 64'h5555_5555_5555_5555, 32'h8000_0000, 1'b0);
    offer_update(2'd1, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000, 1'b0);
    offer_update(2'd1, 32'h5555_5555, 64'h1, 32'h7FFF_FFFF, 1'b0);
    // Board 2: a run of equal scores keeps arrival order; re-scoring to the
    // same value stays put, a lower score drops below its peers.
    for (int i = 1; i <= 5; i++)
      offer_update(2'd2, 32'(i), {$urandom, $urandom}, 32'd100, 1'b0);
    offer_update(2'd2, 32'd2, 64'hDEAD_BEEF_0000_0002, 32'd100, 1'b0);
    offer_update(2'd2, 32'd3, 64'hDEAD_BEEF_0000_0003, 32'd99, 1'b0);
    offer_update(2'd2, 32'd5, 64'hDEAD_BEEF_0000_0005, 32'd101, 1'b0);
    // Board 3: scores around zero and the signed extremes.
    offer_update(2'd3, 32'd7, {$urandom, $urandom}, 32'hFFFF_FFFF, 1'b0);
    offer_update(2'd3, 32'd8, {$urandom, $urandom}, 32'd1, 1'b0);
    offer_update(2'd3, 32'd9, {$urandom, $urandom}, 32'h8000_0000, 1'b0);
    offer_update(2'd3, 32'd10, {$urandom, $urandom}, 32'h7FFF_FFFF, 1'b0);
    offer_update(2'd3, 32'd10, {$urandom, $urandom}, 32'h8000_0001, 1'b0);
    offer_update(2'd3, 32'd0, {$urandom, $urandom}, 32'h7FFF_FFFE, 1'b0);

    // Random updates; the sink takes its long hold early on, and idling
    // stops for the final stretch.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
      if (n == HOLD_AT_ITEM) pressure_go <= 1'b1;
      if (n == RANDOM_ITEMS - CALM_ITEMS) quiet_phase <= 1'b1;
      offer_update(2'($urandom_range(0, 3)), pick_id(), {$urandom, $urandom}, pick_score(),
                   calm);
    end
    s_axis_tvalid <= 1'b0;

    // Let the checker register the last update, drain, then settle.
    @(posedge clk_i);
    while (standings_left != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/tklb_pkg.sv
rtl/core/tklb_ram.sv
rtl/core/tklb_cls.sv
rtl/core/top_k_leaderboard_update_top.sv
rtl/core/tklb_checker.sv
tb/sv/leaderboard_standings_checker.sv
tb/sv/top_k_leaderboard_update_top_tb.sv
